// ===== design/fpdp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdp_pkg
// Shared widths, codes and types of the fp16 negative dot product block.
// ----------------------------------------------------------------------------
package fpdp_pkg;

   localparam int HALF_W   = 16;
   localparam int SINGLE_W = 32;

   localparam logic [SINGLE_W-1:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [SINGLE_W-1:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [7:0]          EXP_MAX   = 8'hFF;
   localparam int                  BIAS      = 127;

   // unpacked binary16 operand, subnormals normalized
   typedef struct packed {
      logic              sign;
      logic signed [6:0] exp;    // unbiased
      logic [10:0]       sig;    // hidden bit at [10]
      logic              zero;
      logic              inf;
      logic              nan;
   } half_type;

   // exact product, registered between the stages
   typedef struct packed {
      logic        sign;
      logic [7:0]  exp;          // biased binary32 exponent
      logic [23:0] sig;          // hidden bit at [23]
      logic        zero;
      logic        inf;
      logic        nan;
      logic        last;
   } prod_type;

   function automatic half_type half_unpack(input logic [HALF_W-1:0] h);
      half_type   u;
      logic [3:0] k;
      k = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h[i]) k = 4'(i);
      end
      u.sign = h[15];
      u.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
      u.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
      u.zero = (h[14:10] == 5'h00) && (h[9:0] == 10'd0);
      if (h[14:10] == 5'h00) begin
         u.sig = 11'({1'b0, h[9:0]}) << (4'd10 - k);
         u.exp = 7'($signed({3'b000, k})) - 7'sd24;
      end else begin
         u.sig = {1'b1, h[9:0]};
         u.exp = 7'($signed({2'b00, h[14:10]})) - 7'sd15;
      end
      return u;
   endfunction

endpackage

// ===== design/fpdp_req_if.sv =====
// ----------------------------------------------------------------------------
// fpdp_req_if
// Element pair channel: valid/ready handshake with two halves and a last flag.
// ----------------------------------------------------------------------------
interface fpdp_req_if import fpdp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] a_half;
   logic [HALF_W-1:0] b_half;
   logic              last_element;

   modport source (output valid, a_half, b_half, last_element, input ready);
   modport sink   (input valid, a_half, b_half, last_element, output ready);
endinterface

// ===== design/fpdp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fpdp_rsp_if
// Result channel: valid/ready handshake carrying the binary32 negated sum.
// ----------------------------------------------------------------------------
interface fpdp_rsp_if import fpdp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SINGLE_W-1:0] neg_dot;

   modport source (output valid, neg_dot, input ready);
   modport sink   (input valid, neg_dot, output ready);
endinterface

// ===== design/fp16_negative_dot_product.sv =====
// ----------------------------------------------------------------------------
// fp16_negative_dot_product
// Streams binary16 element pairs, accumulates their products in binary32
// with round to nearest even and emits the negated sum on the last pair.
// ----------------------------------------------------------------------------
//   channel  dir  transaction               payload
//   req      in   one element pair          a_half, b_half, last_element
//   rsp      out  one negated dot product   neg_dot
//
// One pair per cycle unless a last pair waits on a stalled result. Stage 1
// widens and multiplies (exact 11x11 product), stage 2 adds the product
// into the accumulator in a combinational adder, the loop that sets the
// rate. A result is valid once its last pair has been added in. Reset
// clears the accumulator to +0 and empties the stages. A stalled result holds
// back only a last pair and the input; other pairs keep flowing into the sum.
// ----------------------------------------------------------------------------
module fp16_negative_dot_product import fpdp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   fpdp_req_if.sink     req,
   fpdp_rsp_if.source   rsp
);

   prod_type            prod_ff, prod_in;
   logic                pvalid_ff;
   logic [SINGLE_W-1:0] sum_ff, sum_in;
   logic                ovalid_ff;
   logic [SINGLE_W-1:0] odata_ff, odata_in;
   logic                fire;

   // ---------------- stage 1: widen and multiply ----------------
   half_type          ha, hb;
   logic [21:0]       pm;
   logic signed [9:0] pe;

   always_comb begin
      ha = half_unpack(req.a_half);
      hb = half_unpack(req.b_half);
      pm = 22'(ha.sig) * 22'(hb.sig);
      pe = 10'(ha.exp) + 10'(hb.exp) + 10'(BIAS) + 10'({9'd0, pm[21]});
      prod_in.sign = ha.sign ^ hb.sign;
      prod_in.exp  = pe[7:0];
      prod_in.sig  = pm[21] ? {pm[21:0], 2'b00} : {pm[20:0], 3'b000};
      prod_in.nan  = ha.nan | hb.nan | (ha.inf & hb.zero) | (ha.zero & hb.inf);
      prod_in.inf  = (ha.inf | hb.inf) & ~prod_in.nan;
      prod_in.zero = (ha.zero | hb.zero) & ~prod_in.nan & ~prod_in.inf;
      prod_in.last = req.last_element;
   end

   assign fire      = pvalid_ff && (!prod_ff.last || !ovalid_ff || rsp.ready);
   assign req.ready = !pvalid_ff || fire;

   // ---------------- stage 2: accumulate ----------------
   logic                s_nan, s_inf, s_zero;
   logic [SINGLE_W-1:0] r;
   logic [7:0]          eb, es;
   logic [23:0]         mb, ms, ma;
   logic                sb, swap;
   logic [7:0]          d;
   logic [53:0]         shx;
   logic [26:0]         al;
   logic [27:0]         s28;
   logic [26:0]         n;
   logic [4:0]          msb, lz;
   logic signed [9:0]   e;
   logic [24:0]         m25;

   always_comb begin
      s_nan  = (sum_ff[30:23] == EXP_MAX) && (sum_ff[22:0] != 23'd0);
      s_inf  = (sum_ff[30:23] == EXP_MAX) && (sum_ff[22:0] == 23'd0);
      s_zero = (sum_ff[30:23] == 8'd0);
      ma     = {1'b1, sum_ff[22:0]};
      swap   = {prod_ff.exp, prod_ff.sig} > {sum_ff[30:23], ma};
      sb     = swap ? prod_ff.sign : sum_ff[31];
      eb     = swap ? prod_ff.exp : sum_ff[30:23];
      es     = swap ? sum_ff[30:23] : prod_ff.exp;
      mb     = swap ? prod_ff.sig : ma;
      ms     = swap ? ma : prod_ff.sig;
      d      = eb - es;
      shx    = {ms, 3'b000, 27'd0} >> d[4:0];
      if (d >= 8'd32) begin
         al = 27'd1;
      end else begin
         al = {shx[53:28], shx[27] | (|shx[26:0])};
      end
      if (sum_ff[31] == prod_ff.sign) begin
         s28 = {1'b0, mb, 3'b000} + {1'b0, al};
      end else begin
         s28 = {1'b0, mb, 3'b000} - {1'b0, al};
      end
      // leading one of the sum or difference
      msb = 5'd0;
      for (int i = 0; i < 27; i++) begin
         if (s28[i]) msb = 5'(i);
      end
      lz = 5'd26 - msb;
      if (s28[27]) begin
         n = {s28[27:2], s28[1] | s28[0]};
         e = 10'($signed({2'b00, eb})) + 10'sd1;
      end else begin
         n = s28[26:0] << lz;
         e = 10'($signed({2'b00, eb})) - 10'($signed({5'd0, lz}));
      end
      m25 = {1'b0, n[26:3]} + 25'(n[2] & (n[1] | n[0] | n[3]));
      if (m25[24]) e = e + 10'sd1;

      if (s_nan || prod_ff.nan || (s_inf && prod_ff.inf && (sum_ff[31] != prod_ff.sign))) begin
         r = CANON_NAN;
      end else if (s_inf) begin
         r = sum_ff;
      end else if (prod_ff.inf) begin
         r = {prod_ff.sign, EXP_MAX, 23'd0};
      end else if (prod_ff.zero) begin
         r = s_zero ? {sum_ff[31] & prod_ff.sign, 31'd0} : sum_ff;
      end else if (s_zero) begin
         r = {prod_ff.sign, prod_ff.exp, prod_ff.sig[22:0]};
      end else if (s28 == 28'd0) begin
         r = 32'd0;
      end else if (e >= 10'sd255) begin
         r = {sb, EXP_MAX, 23'd0};
      end else begin
         r = {sb, e[7:0], m25[24] ? 23'd0 : m25[22:0]};
      end

      sum_in   = prod_ff.last ? 32'd0 : r;
      odata_in = ((r[30:23] == EXP_MAX) && (r[22:0] != 23'd0)) ? CANON_NAN : (r ^ SIGN_BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         sum_ff    <= 32'd0;
      end else begin
         if (req.ready) pvalid_ff <= req.valid;
         if (fire) sum_ff <= sum_in;
         if (fire && prod_ff.last) begin
            ovalid_ff <= 1'b1;
         end else if (rsp.ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) prod_ff <= prod_in;
      if (fire && prod_ff.last) odata_ff <= odata_in;
   end

   assign rsp.valid   = ovalid_ff;
   assign rsp.neg_dot = odata_ff;

   // ---------------- assertions ----------------
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      fire && prod_ff.last |=> sum_ff == 32'd0)
      else $error("accumulator not cleared after last pair");

   a_no_subnormal: assert property (@(posedge clock) disable iff (reset)
      sum_ff[30:23] == 8'd0 |-> sum_ff[22:0] == 23'd0)
      else $error("accumulator holds a subnormal");

   a_canon_nan: assert property (@(posedge clock) disable iff (reset)
      sum_ff[30:23] == EXP_MAX && sum_ff[22:0] != 23'd0 |-> sum_ff == CANON_NAN)
      else $error("accumulator NaN not canonical");

   a_stall_last: assert property (@(posedge clock) disable iff (reset)
      pvalid_ff && prod_ff.last && ovalid_ff && !rsp.ready |-> !fire && !req.ready)
      else $error("last pair advanced into a full result register");

endmodule

// ===== sim/fp16_negative_dot_product_tb.sv =====
// ----------------------------------------------------------------------------
// fp16_negative_dot_product_tb
// Streams element pairs with random gaps and result stalls. A bit-exact
// binary32 accumulator model predicts each negated dot product, and every
// result is checked in order against it.
// ----------------------------------------------------------------------------
module fp16_negative_dot_product_tb import fpdp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   class dot_scoreboard;
      logic [SINGLE_W-1:0] running_sum;
      logic [SINGLE_W-1:0] expected_dots[$];
      int                  mismatches;

      function new();
         running_sum = '0;
         mismatches  = 0;
      endfunction

      function automatic bit is_nan(logic [31:0] v);
         return (v[30:23] == EXP_MAX) && (v[22:0] != 0);
      endfunction

      function automatic logic [31:0] widen(logic [15:0] h);
         logic [9:0] man;
         int         ex;
         man = h[9:0];
         if (h[14:10] == 5'h1F) return (man != 0) ? CANON_NAN : {h[15], 8'hFF, 23'd0};
         if (h[14:10] == 5'h00) begin
            if (man == 0) return {h[15], 31'd0};
            ex = 113;
            while (!man[9]) begin
               man = man << 1;
               ex--;
            end
            // one more shift moves the leading one out as the hidden bit
            man = man << 1;
            ex--;
            return {h[15], 8'(ex), man, 13'd0};
         end
         return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
      endfunction

      // product of two widened halves is exact, so no rounding here
      function automatic logic [31:0] mul_exact(logic [31:0] x, logic [31:0] y);
         logic        sgn;
         logic [47:0] p;
         int          m;
         sgn = x[31] ^ y[31];
         if (is_nan(x) || is_nan(y)) return CANON_NAN;
         if (x[30:23] == EXP_MAX || y[30:23] == EXP_MAX) begin
            if (x[30:0] == 0 || y[30:0] == 0) return CANON_NAN;
            return {sgn, 8'hFF, 23'd0};
         end
         if (x[30:0] == 0 || y[30:0] == 0) return {sgn, 31'd0};
         p = {1'b1, x[22:0]} * {1'b1, y[22:0]};
         m = p[47] ? 47 : 46;
         p = p >> (m - 23);
         return {sgn, 8'(int'(x[30:23]) + int'(y[30:23]) + m - 173), p[22:0]};
      endfunction

      // binary32 add, round to nearest even, through an exact wide integer
      function automatic logic [31:0] add_rne(logic [31:0] x, logic [31:0] y);
         logic [299:0] mx, my, mag, keep, rest;
         logic         sgn, guard, sticky;
         int           msb, sh, ef;
         if (is_nan(x) || is_nan(y)) return CANON_NAN;
         if (x[30:23] == EXP_MAX && y[30:23] == EXP_MAX)
            return (x[31] != y[31]) ? CANON_NAN : x;
         if (x[30:23] == EXP_MAX) return x;
         if (y[30:23] == EXP_MAX) return y;
         if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'd0};
         mx = 300'({x[30:23] != 0, x[22:0]}) << ((x[30:23] == 0) ? 0 : x[30:23] - 1);
         my = 300'({y[30:23] != 0, y[22:0]}) << ((y[30:23] == 0) ? 0 : y[30:23] - 1);
         if (x[31] == y[31]) begin
            mag = mx + my;
            sgn = x[31];
         end else if (mx >= my) begin
            mag = mx - my;
            sgn = x[31];
         end else begin
            mag = my - mx;
            sgn = y[31];
         end
         if (mag == 0) return '0;
         msb = 0;
         for (int i = 0; i < 300; i++) if (mag[i]) msb = i;
         if (msb <= 23) return {sgn, mag[30:0]};
         sh     = msb - 23;
         keep   = mag >> sh;
         guard  = mag[sh-1];
         rest   = mag & ((300'd1 << (sh - 1)) - 1);
         sticky = (rest != 0);
         if (guard && (sticky || keep[0])) keep = keep + 1;
         if (keep[24]) begin
            keep = keep >> 1;
            sh++;
         end
         ef = sh + 1;
         if (ef >= 255) return {sgn, 8'hFF, 23'd0};
         return {sgn, 8'(ef), keep[22:0]};
      endfunction

      function void note_pair(logic [15:0] a, logic [15:0] b, logic last);
         logic [31:0] nxt;
         nxt = add_rne(running_sum, mul_exact(widen(a), widen(b)));
         if (is_nan(nxt) || is_nan(running_sum)) nxt = CANON_NAN;
         running_sum = nxt;
         if (last) begin
            expected_dots.push_back(is_nan(running_sum) ? CANON_NAN : running_sum ^ SIGN_BIT);
            running_sum = '0;
         end
      endfunction

      function void check_dot(logic [31:0] actual);
         logic [31:0] want;
         if (expected_dots.size() == 0) begin
            $display("%0t: unexpected neg_dot %h", $time, actual);
            mismatches++;
            return;
         end
         want = expected_dots.pop_front();
         if (actual !== want) begin
            $display("%0t: neg_dot expected %h actual %h", $time, want, actual);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_dots.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   no_gaps;

   fpdp_req_if req();
   fpdp_rsp_if rsp();

   dot_scoreboard board = new();

   fp16_negative_dot_product DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

   // observe transactions with the values present before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_pair(req.a_half, req.b_half, req.last_element);
         if (rsp.valid && rsp.ready) board.check_dot(rsp.neg_dot);
      end
   end

   // result side: random stall per transaction
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp.valid && rsp.ready)) @(posedge clock);
      end
   end

   task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.a_half       <= a;
      req.b_half       <= b;
      req.last_element <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_half();
      // mostly moderate finite values, some raw patterns for full coverage
      if ($urandom_range(0, 9) < 7)
         return {1'($urandom), 5'($urandom_range(5, 22)), 10'($urandom)};
      return 16'($urandom);
   endfunction

   task automatic drain();
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   logic [32:0] directed[$] = '{
      {16'h0000, 16'h0000, 1'b1}, {16'h8000, 16'h0000, 1'b1},
      {16'h8000, 16'h3C00, 1'b0}, {16'h8000, 16'h3C00, 1'b1},
      {16'h7BFF, 16'h7BFF, 1'b0}, {16'hFBFF, 16'h7BFF, 1'b1},
      {16'h0001, 16'h0001, 1'b1}, {16'h03FF, 16'h8400, 1'b1},
      {16'h7C00, 16'h3C00, 1'b0}, {16'hFC00, 16'h3C00, 1'b1},
      {16'h7E00, 16'h0000, 1'b1}, {16'h7C00, 16'h0000, 1'b1},
      {16'h7C00, 16'h7C00, 1'b1}, {16'hFFFF, 16'h3C00, 1'b1},
      {16'h3C00, 16'h3C00, 1'b0}, {16'hBC00, 16'h3C00, 1'b1},
      {16'h3555, 16'h0401, 1'b0}, {16'h8001, 16'h3C01, 1'b0},
      {16'h5A5A, 16'hA5A5, 1'b1}
   };

   initial begin
      int len;
      int sent;
      reset            = 1'b1;
      no_gaps          = 1'b0;
      req.valid        = 1'b0;
      req.a_half       = '0;
      req.b_half       = '0;
      req.last_element = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_pair(directed[i][32:17], directed[i][16:1], directed[i][0]);
      req.valid <= 1'b0;
      drain();

      sent = 0;
      while (sent < 550) begin
         if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         for (int k = 1; k <= len; k++) begin
            send_pair(pick_half(), pick_half(), k == len);
         end
         sent += len;
         if ($urandom_range(0, 11) == 0) begin
            req.valid <= 1'b0;
            drain();
         end
      end
      // a trailing pair without a last flag is summed into the next pair's result
      send_pair(pick_half(), pick_half(), 1'b0);
      send_pair(pick_half(), pick_half(), 1'b1);
      req.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
